[rtl/dtm_pkg.sv]
// ----------------------------------------------------------------------------
// dtm_pkg
// shared types, codes and sizes of the debug trigger match unit
// ----------------------------------------------------------------------------
package dtm_pkg;

	localparam int NUM_POINTS = 8;
	localparam int ADDR_WIDTH = 32;
	localparam int IDX_W      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int CNT_W      = $clog2(NUM_POINTS + 1);
	localparam int CNTX_W     = (CNT_W > 4) ? CNT_W : 4;

	typedef logic [ADDR_WIDTH-1:0] addr_t;
	typedef logic [1:0]            attr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [IDX_W-1:0]      idx_t;

	// function codes
	localparam logic [1:0] FN_MATCH  = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_REMOVE = 2'd2;

	// point types
	localparam logic [2:0] PT_SWBREAK = 3'd0;
	localparam logic [2:0] PT_HWBREAK = 3'd1;
	localparam logic [2:0] PT_WATCH   = 3'd2;
	localparam logic [2:0] PT_AWATCH  = 3'd4;

	// watch kinds as stored in the watch table
	localparam attr_t WK_WRITE  = 2'd0;
	localparam attr_t WK_READ   = 2'd1;
	localparam attr_t WK_ACCESS = 2'd2;

	// signal codes
	localparam logic [1:0] SIG_NONE    = 2'd0;
	localparam logic [1:0] SIG_TRAP    = 2'd1;
	localparam logic [1:0] SIG_ILLEGAL = 2'd2;

	// stop reasons
	localparam logic [2:0] RSN_NONE    = 3'd0;
	localparam logic [2:0] RSN_SWBREAK = 3'd1;
	localparam logic [2:0] RSN_HWBREAK = 3'd2;
	localparam logic [2:0] RSN_WATCH   = 3'd3;

	localparam logic [31:0] EBREAK_WORD   = 32'h0010_0073;
	localparam logic [15:0] C_EBREAK_HALF = 16'h9002;

	// request to one point table
	typedef struct packed {
		logic  en;
		logic  ins;
		logic  rem;
		attr_t attr;
	} tbl_op_t;

	// answer of one point table
	typedef struct packed {
		logic  hit;
		attr_t hit_attr;
		cnt_t  count;
		logic  full;
	} tbl_res_t;

	function automatic addr_t to_addr(input logic [31:0] a);
		logic [ADDR_WIDTH+31:0] ext;
		ext = {{ADDR_WIDTH{1'b0}}, a};
		return ext[ADDR_WIDTH-1:0];
	endfunction

endpackage

[rtl/dtm_table.sv]
// ----------------------------------------------------------------------------
// dtm_table
// one point table: parallel lookup, insert, remove and entry count
// ----------------------------------------------------------------------------
module dtm_table (
	input  logic             clk,
	input  logic             arst_n,
	input  dtm_pkg::addr_t   lookup_addr,
	input  dtm_pkg::addr_t   op_addr,
	input  dtm_pkg::tbl_op_t op,
	output dtm_pkg::tbl_res_t res
);
	import dtm_pkg::*;

	logic [NUM_POINTS-1:0] valid_q;
	addr_t                 addr_q [NUM_POINTS];
	attr_t                 attr_q [NUM_POINTS];
	cnt_t                  count_q;

	logic  found;
	idx_t  found_idx;
	logic  has_free;
	idx_t  free_idx;
	logic  look_hit;
	attr_t look_attr;
	logic  do_alloc;
	logic  do_write;
	logic  do_clear;
	idx_t  wr_idx;
	cnt_t  count_nx;

	// lowest matching or free slot wins
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		has_free  = 1'b0;
		free_idx  = '0;
		look_hit  = 1'b0;
		look_attr = '0;
		for (int i = NUM_POINTS - 1; i >= 0; i--) begin
			if (valid_q[i] && addr_q[i] == op_addr) begin
				found     = 1'b1;
				found_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = IDX_W'(i);
			end
			if (valid_q[i] && addr_q[i] == lookup_addr) begin
				look_hit  = 1'b1;
				look_attr = attr_q[i];
			end
		end
	end

	always_comb begin
		do_alloc = op.ins && !found && has_free;
		do_write = op.ins && (found || has_free);
		do_clear = op.rem && found;
		wr_idx   = found ? found_idx : free_idx;
		count_nx = count_q;
		if (do_alloc) begin
			count_nx = count_q + cnt_t'(1);
		end else if (do_clear) begin
			count_nx = count_q - cnt_t'(1);
		end
		res.hit      = look_hit;
		res.hit_attr = look_attr;
		res.count    = count_nx;
		res.full     = op.ins && !found && !has_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (op.en) begin
			if (do_write) begin
				valid_q[wr_idx] <= 1'b1;
			end else if (do_clear) begin
				valid_q[found_idx] <= 1'b0;
			end
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (op.en && do_write) begin
			addr_q[wr_idx] <= op_addr;
			attr_q[wr_idx] <= op.attr;
		end
	end

endmodule

[rtl/debug_trigger_match_unit_core.sv]
// ----------------------------------------------------------------------------
// debug_trigger_match_unit_core
// breakpoint and watchpoint trigger unit for a retired instruction stream
//
//  channel | group              | payload
//  --------+--------------------+------------------------------------------
//  input   | s_tvalid/s_tready  | s_tdata item fields, s_tuser function code
//  output  | m_tvalid/m_tready  | m_tdata result fields
//
// one item per cycle while the output is not stalled; the accepting edge loads the
// input register, then table lookup and update feed the result register, which
// raises m_tvalid. tables update when the item leaves the input register, so the
// next item already sees the change
// reset empties both tables; a stalled output holds the item in the input
// register and drops s_tready only when both registers are full
// ----------------------------------------------------------------------------
module debug_trigger_match_unit_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_type, point_addr, inst_addr, inst_word, inst_illegal, mem_addr,
	// mem_read, mem_write
	input  logic [135:0] s_tdata,
	// func
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit, signal_code, reason, entry_count, table_full
	output logic [15:0]  m_tdata
);
	import dtm_pkg::*;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [2:0]  point_type_s1;
	logic [31:0] point_addr_s1;
	logic [31:0] inst_addr_s1;
	logic [31:0] inst_word_s1;
	logic        inst_illegal_s1;
	logic [31:0] mem_addr_s1;
	logic        mem_read_s1;
	logic        mem_write_s1;

	logic        out_valid_q;
	logic [15:0] out_data_q;

	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1         <= s_tuser;
			point_type_s1   <= s_tdata[2:0];
			point_addr_s1   <= s_tdata[34:3];
			inst_addr_s1    <= s_tdata[66:35];
			inst_word_s1    <= s_tdata[98:67];
			inst_illegal_s1 <= s_tdata[99];
			mem_addr_s1     <= s_tdata[131:100];
			mem_read_s1     <= s_tdata[132];
			mem_write_s1    <= s_tdata[133];
		end
	end

	// table requests
	logic       is_match;
	logic       is_tbl_op;
	logic       is_brk;
	logic [2:0] wat_type;
	tbl_op_t    brk_op;
	tbl_op_t    wat_op;
	tbl_res_t   brk_res;
	tbl_res_t   wat_res;

	always_comb begin
		is_match  = func_s1 == FN_MATCH;
		is_tbl_op = (func_s1 == FN_INSERT || func_s1 == FN_REMOVE)
			&& point_type_s1 <= PT_AWATCH;
		is_brk    = point_type_s1 <= PT_HWBREAK;
		wat_type  = point_type_s1 - PT_WATCH;

		brk_op.ins  = is_tbl_op && is_brk && func_s1 == FN_INSERT;
		brk_op.rem  = is_tbl_op && is_brk && func_s1 == FN_REMOVE;
		brk_op.en   = advance && is_tbl_op && is_brk;
		brk_op.attr = {1'b0, point_type_s1 == PT_HWBREAK};

		wat_op.ins  = is_tbl_op && !is_brk && func_s1 == FN_INSERT;
		wat_op.rem  = is_tbl_op && !is_brk && func_s1 == FN_REMOVE;
		wat_op.en   = advance && is_tbl_op && !is_brk;
		wat_op.attr = wat_type[1:0];
	end

	dtm_table u_brk (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_addr (to_addr(inst_addr_s1)),
		.op_addr     (to_addr(point_addr_s1)),
		.op          (brk_op),
		.res         (brk_res)
	);

	dtm_table u_wat (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_addr (to_addr(mem_addr_s1)),
		.op_addr     (to_addr(point_addr_s1)),
		.op          (wat_op),
		.res         (wat_res)
	);

	// result
	logic              hit;
	logic [1:0]        signal_code;
	logic [2:0]        reason;
	logic [3:0]        entry_count;
	logic              table_full;
	logic [CNTX_W-1:0] count_x;
	logic              wat_fire;
	attr_t             wk;

	always_comb begin
		hit         = 1'b0;
		signal_code = SIG_NONE;
		reason      = RSN_NONE;
		entry_count = '0;
		table_full  = 1'b0;
		wk          = wat_res.hit_attr;
		wat_fire    = wat_res.hit && ((wk == WK_WRITE && mem_write_s1)
			|| (wk == WK_READ && mem_read_s1)
			|| (wk == WK_ACCESS && (mem_read_s1 || mem_write_s1)));
		count_x     = is_brk ? CNTX_W'(brk_res.count) : CNTX_W'(wat_res.count);
		if (is_match) begin
			if (inst_illegal_s1) begin
				hit         = 1'b1;
				signal_code = SIG_ILLEGAL;
			end else if (inst_word_s1 == EBREAK_WORD
				|| inst_word_s1[15:0] == C_EBREAK_HALF) begin
				hit         = 1'b1;
				signal_code = SIG_TRAP;
				reason      = RSN_SWBREAK;
			end else if (brk_res.hit && brk_res.hit_attr[0]) begin
				hit         = 1'b1;
				signal_code = SIG_TRAP;
				reason      = RSN_HWBREAK;
			end else if (wat_fire) begin
				hit         = 1'b1;
				signal_code = SIG_TRAP;
				reason      = RSN_WATCH + {1'b0, wk};
			end
		end else if (is_tbl_op) begin
			entry_count = count_x[3:0];
			table_full  = is_brk ? brk_res.full : wat_res.full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {5'd0, table_full, entry_count, reason, signal_code, hit};
		end
	end

endmodule

[bench/debug_trigger_match_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// debug_trigger_match_unit_core_tb
// self-checking bench for the breakpoint and watchpoint trigger unit
//
// a local model of both point tables predicts the result of every accepted
// item; a monitor compares each result field by field in arrival order.
// directed tests cover match priority, break and watch kinds, a full table
// and unused codes, then random traffic over a small address pool keeps the
// tables busy. both stream sides idle at random between items, except in the gap-free phases of the random traffic.
// ----------------------------------------------------------------------------
module debug_trigger_match_unit_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dtm_pkg::*;

	localparam logic [1:0]  FN_UNUSED     = 2'd3;
	localparam logic [2:0]  PT_RWATCH     = 3'd3;
	localparam logic [2:0]  RSN_RWATCH    = 3'd4;
	localparam logic [2:0]  RSN_AWATCH    = 3'd5;
	localparam logic [31:0] NOP_WORD      = 32'h0000_0013;
	localparam int          RANDOM_ITEMS  = 2000;
	localparam int          POOL_SIZE     = 12;
	localparam int          EXP_DEPTH     = 4096;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  point_type;
		logic [31:0] point_addr;
		logic [31:0] inst_addr;
		logic [31:0] inst_word;
		logic        inst_illegal;
		logic [31:0] mem_addr;
		logic        mem_read;
		logic        mem_write;
	} trig_item_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] signal_code;
		logic [2:0] reason;
		logic [3:0] entry_count;
		logic       table_full;
	} trig_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// point_type, point_addr, inst_addr, inst_word, inst_illegal, mem_addr,
	// mem_read, mem_write
	logic [135:0] s_tdata = '0;
	// func
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// hit, signal_code, reason, entry_count, table_full
	logic [15:0]  m_tdata;

	// model of the two point tables
	bit           bp_used [NUM_POINTS];
	addr_t        bp_addr [NUM_POINTS];
	bit           bp_hw   [NUM_POINTS];
	bit           wp_used [NUM_POINTS];
	addr_t        wp_addr [NUM_POINTS];
	attr_t        wp_kind [NUM_POINTS];

	// expected results in accept order
	trig_result_t expected_results [EXP_DEPTH];
	int           exp_wr = 0;
	int           exp_rd = 0;
	logic [31:0]  addr_pool [POOL_SIZE];
	bit           no_gaps = 1'b0;
	int           mismatches = 0;
	int           items_sent = 0;
	int           results_seen = 0;
	int           stops_seen = 0;
	int           full_seen = 0;

	debug_trigger_match_unit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic int find_breakpoint(input addr_t a);
		int s;
		s = -1;
		for (int i = NUM_POINTS - 1; i >= 0; i--)
			if (bp_used[i] && bp_addr[i] == a)
				s = i;
		return s;
	endfunction

	function automatic int find_watchpoint(input addr_t a);
		int s;
		s = -1;
		for (int i = NUM_POINTS - 1; i >= 0; i--)
			if (wp_used[i] && wp_addr[i] == a)
				s = i;
		return s;
	endfunction

	// updates the table model and returns the result the item must give
	function automatic trig_result_t predict_trigger(input trig_item_t it);
		trig_result_t r;
		int           slot;
		int           used;
		bit           is_brk;
		attr_t        k;
		r = '0;
		if (it.func == FN_MATCH) begin
			if (it.inst_illegal) begin
				r.hit = 1'b1;
				r.signal_code = SIG_ILLEGAL;
			end else if (it.inst_word == EBREAK_WORD ||
			             it.inst_word[15:0] == C_EBREAK_HALF) begin
				r.hit = 1'b1;
				r.signal_code = SIG_TRAP;
				r.reason = RSN_SWBREAK;
			end else begin
				slot = find_breakpoint(addr_t'(it.inst_addr));
				if (slot >= 0 && bp_hw[slot]) begin
					r.hit = 1'b1;
					r.signal_code = SIG_TRAP;
					r.reason = RSN_HWBREAK;
				end else begin
					// a software breakpoint at the pc falls through to the watch table
					slot = find_watchpoint(addr_t'(it.mem_addr));
					if (slot >= 0) begin
						k = wp_kind[slot];
						if ((k == WK_WRITE && it.mem_write) || (k == WK_READ && it.mem_read) ||
						    (k == WK_ACCESS && (it.mem_read || it.mem_write))) begin
							r.hit = 1'b1;
							r.signal_code = SIG_TRAP;
							r.reason = RSN_WATCH + 3'(k);
						end
					end
				end
			end
		end else if ((it.func == FN_INSERT || it.func == FN_REMOVE) &&
		             it.point_type <= PT_AWATCH) begin
			is_brk = it.point_type <= PT_HWBREAK;
			slot = is_brk ? find_breakpoint(addr_t'(it.point_addr))
			              : find_watchpoint(addr_t'(it.point_addr));
			if (it.func == FN_INSERT) begin
				if (slot < 0) begin
					for (int i = NUM_POINTS - 1; i >= 0; i--)
						if (is_brk ? !bp_used[i] : !wp_used[i])
							slot = i;
					if (slot >= 0) begin
						if (is_brk) begin
							bp_used[slot] = 1'b1;
							bp_addr[slot] = addr_t'(it.point_addr);
						end else begin
							wp_used[slot] = 1'b1;
							wp_addr[slot] = addr_t'(it.point_addr);
						end
					end
				end
				if (slot >= 0) begin
					if (is_brk)
						bp_hw[slot] = (it.point_type == PT_HWBREAK);
					else
						wp_kind[slot] = attr_t'(it.point_type - PT_WATCH);
				end else begin
					r.table_full = 1'b1;
				end
			end else if (slot >= 0) begin
				if (is_brk)
					bp_used[slot] = 1'b0;
				else
					wp_used[slot] = 1'b0;
			end
			used = 0;
			for (int i = 0; i < NUM_POINTS; i++)
				used += is_brk ? bp_used[i] : wp_used[i];
			r.entry_count = 4'(used);
		end
		return r;
	endfunction

	function automatic trig_item_t match_item(input logic [31:0] iaddr,
	                                          input logic [31:0] iword,
	                                          input logic ill, input logic [31:0] maddr,
	                                          input logic rd, input logic wr);
		trig_item_t it;
		it.func         = FN_MATCH;
		it.point_type   = 3'($urandom_range(0, 7));
		it.point_addr   = $urandom;
		it.inst_addr    = iaddr;
		it.inst_word    = iword;
		it.inst_illegal = ill;
		it.mem_addr     = maddr;
		it.mem_read     = rd;
		it.mem_write    = wr;
		return it;
	endfunction

	function automatic trig_item_t point_item(input logic [1:0] fn, input logic [2:0] ptype,
	                                          input logic [31:0] addr);
		trig_item_t it;
		it = match_item($urandom, $urandom, 1'($urandom), $urandom, 1'($urandom),
		                1'($urandom));
		it.func       = fn;
		it.point_type = ptype;
		it.point_addr = addr;
		return it;
	endfunction

	function automatic logic [31:0] pool_addr();
		return ($urandom_range(0, 9) < 9) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
		                                  : $urandom;
	endfunction

	task automatic send_item(input trig_item_t it);
		int           gap;
		trig_result_t r;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {2'b00, it.mem_write, it.mem_read, it.mem_addr, it.inst_illegal,
		             it.inst_word, it.inst_addr, it.point_addr, it.point_type};
		do @(posedge clk); while (!s_tready);
		r = predict_trigger(it);
		expected_results[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
		items_sent++;
		stops_seen += r.hit;
		full_seen  += r.table_full;
	endtask

	// receiver stalls
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		trig_result_t want;
		trig_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit         = m_tdata[0];
			got.signal_code = m_tdata[2:1];
			got.reason      = m_tdata[5:3];
			got.entry_count = m_tdata[9:6];
			got.table_full  = m_tdata[10];
			results_seen++;
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no item pending: %h", $realtime, m_tdata);
			end else begin
				want = expected_results[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (got.hit !== want.hit || got.signal_code !== want.signal_code ||
				    got.reason !== want.reason || got.entry_count !== want.entry_count ||
				    got.table_full !== want.table_full) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: result %0d expected hit=%0d sig=%0d rsn=%0d ",
						          "cnt=%0d full=%0d, got hit=%0d sig=%0d rsn=%0d ",
						          "cnt=%0d full=%0d"},
						         $realtime, results_seen, want.hit, want.signal_code,
						         want.reason, want.entry_count, want.table_full, got.hit,
						         got.signal_code, got.reason, got.entry_count,
						         got.table_full);
				end
			end
		end
	end

	// empty tables, illegal before ebreak, both ebreak encodings
	task automatic test_match_priority();
		send_item(match_item(32'h0, NOP_WORD, 1'b0, 32'h0, 1'b1, 1'b1));
		send_item(match_item($urandom, EBREAK_WORD, 1'b1, $urandom, 1'b1, 1'b0));
		send_item(match_item($urandom, EBREAK_WORD, 1'b0, $urandom, 1'b0, 1'b1));
		send_item(match_item($urandom, {16'hFFFF, C_EBREAK_HALF}, 1'b0, $urandom, 1'b0, 1'b0));
		send_item(match_item($urandom, EBREAK_WORD ^ 32'h1, 1'b0, $urandom, 1'b1, 1'b1));
	endtask

	task automatic test_breakpoints();
		send_item(point_item(FN_INSERT, PT_HWBREAK, 32'hFFFF_FFFF));
		send_item(match_item(32'hFFFF_FFFF, NOP_WORD, 1'b0, 32'h1000, 1'b1, 1'b1));
		send_item(point_item(FN_INSERT, PT_SWBREAK, 32'h0));
		send_item(point_item(FN_INSERT, PT_WATCH, 32'h1000));
		// software breakpoint at the pc, so the write watch decides
		send_item(match_item(32'h0, NOP_WORD, 1'b0, 32'h1000, 1'b0, 1'b1));
		send_item(point_item(FN_INSERT, PT_SWBREAK, 32'hFFFF_FFFF));
		send_item(match_item(32'hFFFF_FFFF, NOP_WORD, 1'b0, 32'h1000, 1'b1, 1'b0));
	endtask

	task automatic test_watch_kinds();
		send_item(point_item(FN_INSERT, PT_RWATCH, 32'h2000));
		send_item(point_item(FN_INSERT, PT_AWATCH, 32'h3000));
		send_item(match_item(32'h40, NOP_WORD, 1'b0, 32'h2000, 1'b1, 1'b0));
		send_item(match_item(32'h40, NOP_WORD, 1'b0, 32'h2000, 1'b0, 1'b1));
		send_item(match_item(32'h40, NOP_WORD, 1'b0, 32'h3000, 1'b0, 1'b0));
		send_item(match_item(32'h40, NOP_WORD, 1'b0, 32'h3000, 1'b1, 1'b1));
	endtask

	task automatic test_table_full();
		for (int i = 0; i < 5; i++)
			send_item(point_item(FN_INSERT, PT_WATCH, 32'h8000_0000 + 4 * i));
		send_item(point_item(FN_INSERT, PT_RWATCH, 32'hDEAD_BEEC));
		// an address already present is retyped even when the table is full
		send_item(point_item(FN_INSERT, PT_AWATCH, 32'h1000));
		send_item(point_item(FN_REMOVE, PT_WATCH, 32'hDEAD_BEEC));
		send_item(point_item(FN_REMOVE, PT_AWATCH, 32'h1000));
	endtask

	task automatic test_unused_codes();
		send_item(point_item(FN_UNUSED, PT_HWBREAK, 32'h2000));
		send_item(point_item(FN_INSERT, 3'd5, 32'h5000));
		send_item(point_item(FN_REMOVE, 3'd7, 32'h2000));
	endtask

	// alternating insert-heavy and remove-heavy phases over a small pool
	task automatic test_random_traffic(input int n_items);
		trig_item_t  it;
		int          pick;
		int          ins_w;
		int          rem_w;
		logic [2:0]  ptype;
		logic [31:0] word;
		addr_pool[0] = 32'h0;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;
		ins_w = 15;
		rem_w = 25;
		for (int k = 0; k < n_items; k++) begin
			if (k % 250 == 0) begin
				no_gaps = ((k / 250) % 4 == 3);
				ins_w = ((k / 250) % 2) ? 35 : 15;
				rem_w = ((k / 250) % 2) ? 10 : 25;
			end
			pick = $urandom_range(0, 99);
			ptype = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 4))
			                                     : 3'($urandom_range(5, 7));
			if (pick < ins_w) begin
				it = point_item(FN_INSERT, ptype, pool_addr());
			end else if (pick < ins_w + rem_w) begin
				it = point_item(FN_REMOVE, ptype, pool_addr());
			end else if (pick < ins_w + rem_w + 3) begin
				it = point_item(FN_UNUSED, ptype, pool_addr());
			end else begin
				case ($urandom_range(0, 15))
					0:       word = EBREAK_WORD;
					1:       word = {16'($urandom), C_EBREAK_HALF};
					default: word = $urandom;
				endcase
				it = match_item(($urandom_range(0, 9) < 6) ? pool_addr() : $urandom, word,
				                $urandom_range(0, 15) == 0,
				                ($urandom_range(0, 9) < 6) ? pool_addr() : $urandom,
				                1'($urandom), 1'($urandom));
			end
			send_item(it);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_match_priority();
		test_breakpoints();
		test_watch_kinds();
		test_table_full();
		test_unused_codes();
		test_random_traffic(RANDOM_ITEMS);
		s_tvalid <= 1'b0;
		wait (exp_wr == exp_rd);
		repeat (6) @(posedge clk);
		mismatches += exp_wr - exp_rd;
		$display("run covered %0d items and %0d results: %0d stops, %0d table-full reports",
		         items_sent, results_seen, stops_seen, full_seen);
		if (mismatches == 0)
			$display("debug_trigger_match_unit_core: match");
		else
			$display("debug_trigger_match_unit_core: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("debug_trigger_match_unit_core: mismatch");
		$finish;
	end

endmodule
